[rtl/ftfe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftfe_pkg
// Types, widths, normal table and pipeline layout of the fingertip taxel
// force estimator.
// ----------------------------------------------------------------------------
package ftfe_pkg;

	localparam int LANE_MAX   = 12;
	localparam int TAXEL_W    = 12;
	localparam int COEF_W     = 16;
	localparam int PROD_W     = 28;
	localparam int GROUP_SIZE = 4;
	localparam int PART_W     = 30;
	localparam int ACC_W      = 32;
	localparam int MAG_W      = 31;
	localparam int SQ_W       = 62;
	localparam int RAD_W      = 32;
	localparam int FRAC_DROP  = SQ_W - RAD_W;
	localparam int ROOT_W     = 16;
	localparam int REM_W      = ROOT_W + 1;
	localparam int PSUM_W     = 14;
	localparam int SUM_W      = 16;
	localparam int FORCE_W    = 16;
	localparam int MODE_W     = 2;

	localparam logic [FORCE_W-1:0] FORCE_MAX = 16'd49140;

	// pipeline layout: lane products, two adder levels, square, sum of
	// squares, one stage per root bit, output register
	localparam int ST_LANE   = 0;
	localparam int ST_MERGE  = 1;
	localparam int ST_SQUARE = 3;
	localparam int ST_SQRT   = 5;
	localparam int ST_OUT    = ST_SQRT + ROOT_W;
	localparam int STAGES    = ST_OUT + 1;

	typedef enum logic [MODE_W-1:0] {
		MODE_SUM    = 2'd0,
		MODE_VECTOR = 2'd1,
		MODE_ZERO   = 2'd2
	} force_mode_t;

	typedef logic [TAXEL_W-1:0] taxel_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] x;
		logic signed [PROD_W-1:0] y;
		logic signed [PROD_W-1:0] z;
	} prod_vec_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] x;
		logic signed [ACC_W-1:0] y;
		logic signed [ACC_W-1:0] z;
	} acc_vec_t;

	// unit surface normals, Q1.15
	localparam logic signed [COEF_W-1:0] NORMAL_X [LANE_MAX] = '{
		-16'sd32767, -16'sd13093, -16'sd13093, -16'sd32767,
		-16'sd25780, -16'sd10128,  16'sd0,      16'sd10128,
		 16'sd25780,  16'sd32767,  16'sd13093,  16'sd13093
	};
	localparam logic signed [COEF_W-1:0] NORMAL_Y [LANE_MAX] = '{
		16'sd0,     16'sd0,     16'sd0,     16'sd0,
		16'sd19764, 16'sd15652, 16'sd32767, 16'sd15652,
		16'sd19764, 16'sd0,     16'sd0,     16'sd0
	};
	localparam logic signed [COEF_W-1:0] NORMAL_Z [LANE_MAX] = '{
		16'sd0,     16'sd30039, 16'sd30039, 16'sd0,
		16'sd4306,  16'sd26948, 16'sd0,     16'sd26948,
		16'sd4306,  16'sd0,     16'sd30039, 16'sd30039
	};

endpackage
`default_nettype wire

[rtl/ftfe_frame_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftfe_frame_if
// Frame channel: twelve taxel pressures per word.
// ----------------------------------------------------------------------------
interface ftfe_frame_if;
	logic                   valid;
	logic                   ready;
	ftfe_pkg::taxel_t       taxel_0;
	ftfe_pkg::taxel_t       taxel_1;
	ftfe_pkg::taxel_t       taxel_2;
	ftfe_pkg::taxel_t       taxel_3;
	ftfe_pkg::taxel_t       taxel_4;
	ftfe_pkg::taxel_t       taxel_5;
	ftfe_pkg::taxel_t       taxel_6;
	ftfe_pkg::taxel_t       taxel_7;
	ftfe_pkg::taxel_t       taxel_8;
	ftfe_pkg::taxel_t       taxel_9;
	ftfe_pkg::taxel_t       taxel_10;
	ftfe_pkg::taxel_t       taxel_11;

	modport source (
		output valid, taxel_0, taxel_1, taxel_2, taxel_3, taxel_4, taxel_5,
		taxel_6, taxel_7, taxel_8, taxel_9, taxel_10, taxel_11,
		input  ready
	);
	modport sink (
		input  valid, taxel_0, taxel_1, taxel_2, taxel_3, taxel_4, taxel_5,
		taxel_6, taxel_7, taxel_8, taxel_9, taxel_10, taxel_11,
		output ready
	);
endinterface
`default_nettype wire

[rtl/ftfe_estimate_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftfe_estimate_if
// Result channel: one force estimate per word.
// ----------------------------------------------------------------------------
interface ftfe_estimate_if;
	logic                           valid;
	logic                           ready;
	logic [ftfe_pkg::FORCE_W-1:0]   force_estimate;

	modport source (output valid, force_estimate, input ready);
	modport sink (input valid, force_estimate, output ready);
endinterface
`default_nettype wire

[rtl/ftfe_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftfe_cfg_if
// Configuration write channel for the mode register.
// ----------------------------------------------------------------------------
interface ftfe_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ftfe_pkg::MODE_W-1:0]    force_mode;

	modport source (output valid, force_mode, input ready);
	modport sink (input valid, force_mode, output ready);
endinterface
`default_nettype wire

[rtl/ftfe_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftfe_lane
// One taxel lane: scales the pressure by the three normal coefficients.
// ----------------------------------------------------------------------------
module ftfe_lane #(
	parameter int LANE = 0
) (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire ftfe_pkg::taxel_t    taxel,
	output ftfe_pkg::prod_vec_t      prod_s1,
	output ftfe_pkg::taxel_t         taxel_s1
);

	localparam logic signed [ftfe_pkg::COEF_W-1:0] CX = ftfe_pkg::NORMAL_X[LANE];
	localparam logic signed [ftfe_pkg::COEF_W-1:0] CY = ftfe_pkg::NORMAL_Y[LANE];
	localparam logic signed [ftfe_pkg::COEF_W-1:0] CZ = ftfe_pkg::NORMAL_Z[LANE];

	logic signed [ftfe_pkg::TAXEL_W:0] p;
	logic signed [ftfe_pkg::PROD_W:0]  px;
	logic signed [ftfe_pkg::PROD_W:0]  py;
	logic signed [ftfe_pkg::PROD_W:0]  pz;

	always_comb begin
		p  = $signed({1'b0, taxel});
		px = p * CX;
		py = p * CY;
		pz = p * CZ;
	end

	// |taxel * coef| stays below 2^27, so the top bit is sign only
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1.x <= px[ftfe_pkg::PROD_W-1:0];
			prod_s1.y <= py[ftfe_pkg::PROD_W-1:0];
			prod_s1.z <= pz[ftfe_pkg::PROD_W-1:0];
			taxel_s1  <= taxel;
		end
	end

endmodule
`default_nettype wire

[rtl/ftfe_merge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftfe_merge
// Two-level registered adder tree over the lanes: axis sums and plain sum.
// ----------------------------------------------------------------------------
module ftfe_merge #(
	parameter int TAXEL_COUNT = 12
) (
	input  wire logic                   clk,
	input  wire logic [1:0]             en,
	input  wire ftfe_pkg::prod_vec_t    prod [TAXEL_COUNT],
	input  wire ftfe_pkg::taxel_t       taxel [TAXEL_COUNT],
	output ftfe_pkg::acc_vec_t          acc_s3,
	output logic [ftfe_pkg::SUM_W-1:0]  sum_s3
);

	localparam int GROUPS = (TAXEL_COUNT + ftfe_pkg::GROUP_SIZE - 1) / ftfe_pkg::GROUP_SIZE;

	logic signed [ftfe_pkg::PART_W-1:0] gx [GROUPS];
	logic signed [ftfe_pkg::PART_W-1:0] gy [GROUPS];
	logic signed [ftfe_pkg::PART_W-1:0] gz [GROUPS];
	logic [ftfe_pkg::PSUM_W-1:0]        gs [GROUPS];

	logic signed [ftfe_pkg::PART_W-1:0] gx_s2 [GROUPS];
	logic signed [ftfe_pkg::PART_W-1:0] gy_s2 [GROUPS];
	logic signed [ftfe_pkg::PART_W-1:0] gz_s2 [GROUPS];
	logic [ftfe_pkg::PSUM_W-1:0]        gs_s2 [GROUPS];

	logic signed [ftfe_pkg::ACC_W-1:0]  tx;
	logic signed [ftfe_pkg::ACC_W-1:0]  ty;
	logic signed [ftfe_pkg::ACC_W-1:0]  tz;
	logic [ftfe_pkg::SUM_W-1:0]         ts;

	// first level: groups of up to four lanes
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			gx[g] = '0;
			gy[g] = '0;
			gz[g] = '0;
			gs[g] = '0;
			for (int j = 0; j < ftfe_pkg::GROUP_SIZE; j++) begin
				if (g * ftfe_pkg::GROUP_SIZE + j < TAXEL_COUNT) begin
					gx[g] = gx[g] + ftfe_pkg::PART_W'($signed(
						prod[g * ftfe_pkg::GROUP_SIZE + j].x));
					gy[g] = gy[g] + ftfe_pkg::PART_W'($signed(
						prod[g * ftfe_pkg::GROUP_SIZE + j].y));
					gz[g] = gz[g] + ftfe_pkg::PART_W'($signed(
						prod[g * ftfe_pkg::GROUP_SIZE + j].z));
					gs[g] = gs[g] + ftfe_pkg::PSUM_W'(
						taxel[g * ftfe_pkg::GROUP_SIZE + j]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			gx_s2 <= gx;
			gy_s2 <= gy;
			gz_s2 <= gz;
			gs_s2 <= gs;
		end
	end

	// second level: groups into axis totals
	always_comb begin
		tx = '0;
		ty = '0;
		tz = '0;
		ts = '0;
		for (int g = 0; g < GROUPS; g++) begin
			tx = tx + ftfe_pkg::ACC_W'(gx_s2[g]);
			ty = ty + ftfe_pkg::ACC_W'(gy_s2[g]);
			tz = tz + ftfe_pkg::ACC_W'(gz_s2[g]);
			ts = ts + ftfe_pkg::SUM_W'(gs_s2[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			acc_s3.x <= tx;
			acc_s3.y <= ty;
			acc_s3.z <= tz;
			sum_s3   <= ts;
		end
	end

endmodule
`default_nettype wire

[rtl/ftfe_square.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftfe_square
// Squares the three axis sums and adds them into the root radicand.
// ----------------------------------------------------------------------------
module ftfe_square (
	input  wire logic                   clk,
	input  wire logic [1:0]             en,
	input  wire ftfe_pkg::acc_vec_t     acc,
	input  wire logic [ftfe_pkg::SUM_W-1:0] sum,
	output logic [ftfe_pkg::RAD_W-1:0]  rad_s5,
	output logic [ftfe_pkg::SUM_W-1:0]  sum_s5
);

	logic [ftfe_pkg::ACC_W-1:0] neg_x, neg_y, neg_z;
	logic [ftfe_pkg::MAG_W-1:0] mag_x, mag_y, mag_z;
	logic [ftfe_pkg::SQ_W-1:0]  sq_x_s4, sq_y_s4, sq_z_s4;
	logic [ftfe_pkg::SUM_W-1:0] sum_s4;
	logic [ftfe_pkg::SQ_W-1:0]  sq_total;

	// axis sums stay below 2^31 in magnitude
	always_comb begin
		neg_x = -acc.x;
		neg_y = -acc.y;
		neg_z = -acc.z;
		mag_x = acc.x[ftfe_pkg::ACC_W-1] ? neg_x[ftfe_pkg::MAG_W-1:0] : acc.x[ftfe_pkg::MAG_W-1:0];
		mag_y = acc.y[ftfe_pkg::ACC_W-1] ? neg_y[ftfe_pkg::MAG_W-1:0] : acc.y[ftfe_pkg::MAG_W-1:0];
		mag_z = acc.z[ftfe_pkg::ACC_W-1] ? neg_z[ftfe_pkg::MAG_W-1:0] : acc.z[ftfe_pkg::MAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sq_x_s4 <= ftfe_pkg::SQ_W'(mag_x) * ftfe_pkg::SQ_W'(mag_x);
			sq_y_s4 <= ftfe_pkg::SQ_W'(mag_y) * ftfe_pkg::SQ_W'(mag_y);
			sq_z_s4 <= ftfe_pkg::SQ_W'(mag_z) * ftfe_pkg::SQ_W'(mag_z);
			sum_s4  <= sum;
		end
	end

	// unit normals keep the vector length within the taxel sum, so the
	// squared length stays below 2^62
	assign sq_total = sq_x_s4 + sq_y_s4 + sq_z_s4;

	// floor(sqrt(S)) >> 15 equals floor(sqrt(S >> 30))
	always_ff @(posedge clk) begin
		if (en[1]) begin
			rad_s5 <= sq_total[ftfe_pkg::SQ_W-1:ftfe_pkg::FRAC_DROP];
			sum_s5 <= sum_s4;
		end
	end

endmodule
`default_nettype wire

[rtl/ftfe_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftfe_isqrt
// Pipelined restoring integer square root, one root bit per stage; the
// plain sum rides along.
// ----------------------------------------------------------------------------
module ftfe_isqrt (
	input  wire logic                       clk,
	input  wire logic [ftfe_pkg::ROOT_W-1:0] en,
	input  wire logic [ftfe_pkg::RAD_W-1:0]  rad,
	input  wire logic [ftfe_pkg::SUM_W-1:0]  side,
	output logic [ftfe_pkg::ROOT_W-1:0]      root,
	output logic [ftfe_pkg::SUM_W-1:0]       side_out
);

	localparam int N = ftfe_pkg::ROOT_W;

	logic [ftfe_pkg::RAD_W-1:0]  rad_q  [N];
	logic [ftfe_pkg::REM_W-1:0]  rem_q  [N];
	logic [ftfe_pkg::ROOT_W-1:0] root_q [N];
	logic [ftfe_pkg::SUM_W-1:0]  side_q [N];

	for (genvar i = 0; i < N; i++) begin : gen_step
		logic [ftfe_pkg::RAD_W-1:0]  rad_in;
		logic [ftfe_pkg::REM_W-1:0]  rem_in;
		logic [ftfe_pkg::ROOT_W-1:0] root_in;
		logic [ftfe_pkg::SUM_W-1:0]  side_in;
		logic [ftfe_pkg::REM_W+1:0]  rem_sh;
		logic [ftfe_pkg::REM_W+1:0]  trial;
		logic [ftfe_pkg::REM_W+1:0]  diff;
		logic                        take;

		if (i == 0) begin : gen_first
			assign rad_in  = rad;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = side;
		end else begin : gen_next
			assign rad_in  = rad_q[i-1];
			assign rem_in  = rem_q[i-1];
			assign root_in = root_q[i-1];
			assign side_in = side_q[i-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign rem_sh = {rem_in, rad_in[ftfe_pkg::RAD_W-1 -: 2]};
		assign trial  = {1'b0, root_in, 2'b01};
		assign diff   = rem_sh - trial;
		assign take   = (rem_sh >= trial);

		always_ff @(posedge clk) begin
			if (en[i]) begin
				rad_q[i]  <= {rad_in[ftfe_pkg::RAD_W-3:0], 2'b00};
				rem_q[i]  <= take ? diff[ftfe_pkg::REM_W-1:0] : rem_sh[ftfe_pkg::REM_W-1:0];
				root_q[i] <= {root_in[ftfe_pkg::ROOT_W-2:0], take};
				side_q[i] <= side_in;
			end
		end
	end

	assign root     = root_q[N-1];
	assign side_out = side_q[N-1];

endmodule
`default_nettype wire

[rtl/fingertip_taxel_force_estimator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fingertip_taxel_force_estimator
// Fingertip force estimate from one frame of taxel pressures.
// ----------------------------------------------------------------------------
// The block takes one frame per cycle unless a stalled result holds it; each
// estimate leaves when the result side is ready. The pipeline holds the lane
// multiply, two adder levels, squaring, the sum of squares, the sixteen stages
// of the square root (one root bit each) and the output register. Each stage
// holds its word until the next one has room, so a stalled result stops only
// the stages behind it. Mode 0 returns the pressure sum, mode 1 the length of
// the normal-weighted vector, modes 2 and 3 return zero; results are unsigned
// Q16.0 and clamp at 49140. Write the mode only while no frame is in flight.
// ----------------------------------------------------------------------------
module fingertip_taxel_force_estimator #(
	parameter int TAXEL_COUNT = 12
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	ftfe_frame_if.sink      frame,
	ftfe_estimate_if.source estimate,
	ftfe_cfg_if.sink        cfg
);

	localparam int STAGES = ftfe_pkg::STAGES;

	logic [ftfe_pkg::MODE_W-1:0] mode_q;
	logic [STAGES-1:0]           vld_q;
	logic [STAGES-1:0]           en;

	ftfe_pkg::taxel_t    taxel [ftfe_pkg::LANE_MAX];
	ftfe_pkg::taxel_t    taxel_s1 [TAXEL_COUNT];
	ftfe_pkg::prod_vec_t prod_s1 [TAXEL_COUNT];
	ftfe_pkg::acc_vec_t  acc_s3;
	logic [ftfe_pkg::SUM_W-1:0]  sum_s3;
	logic [ftfe_pkg::RAD_W-1:0]  rad_s5;
	logic [ftfe_pkg::SUM_W-1:0]  sum_s5;
	logic [ftfe_pkg::ROOT_W-1:0] root;
	logic [ftfe_pkg::SUM_W-1:0]  sum_fin;
	logic [ftfe_pkg::FORCE_W-1:0] result;
	logic [ftfe_pkg::FORCE_W-1:0] result_q;

	// mode register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ftfe_pkg::MODE_SUM;
		end else if (cfg.valid) begin
			mode_q <= cfg.force_mode;
		end
	end

	// stage flow: a stage loads when it is empty or its word moves on
	assign en[STAGES-1] = !vld_q[STAGES-1] || estimate.ready;
	for (genvar k = 0; k < STAGES - 1; k++) begin : gen_flow
		assign en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= frame.valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign frame.ready    = en[0];
	assign estimate.valid = vld_q[STAGES-1];

	assign taxel[0]  = frame.taxel_0;
	assign taxel[1]  = frame.taxel_1;
	assign taxel[2]  = frame.taxel_2;
	assign taxel[3]  = frame.taxel_3;
	assign taxel[4]  = frame.taxel_4;
	assign taxel[5]  = frame.taxel_5;
	assign taxel[6]  = frame.taxel_6;
	assign taxel[7]  = frame.taxel_7;
	assign taxel[8]  = frame.taxel_8;
	assign taxel[9]  = frame.taxel_9;
	assign taxel[10] = frame.taxel_10;
	assign taxel[11] = frame.taxel_11;

	for (genvar i = 0; i < TAXEL_COUNT; i++) begin : gen_lane
		ftfe_lane #(
			.LANE (i)
		) u_lane (
			.clk      (clk),
			.en       (en[ftfe_pkg::ST_LANE]),
			.taxel    (taxel[i]),
			.prod_s1  (prod_s1[i]),
			.taxel_s1 (taxel_s1[i])
		);
	end

	ftfe_merge #(
		.TAXEL_COUNT (TAXEL_COUNT)
	) u_merge (
		.clk    (clk),
		.en     (en[ftfe_pkg::ST_MERGE +: 2]),
		.prod   (prod_s1),
		.taxel  (taxel_s1),
		.acc_s3 (acc_s3),
		.sum_s3 (sum_s3)
	);

	ftfe_square u_square (
		.clk    (clk),
		.en     (en[ftfe_pkg::ST_SQUARE +: 2]),
		.acc    (acc_s3),
		.sum    (sum_s3),
		.rad_s5 (rad_s5),
		.sum_s5 (sum_s5)
	);

	ftfe_isqrt u_isqrt (
		.clk      (clk),
		.en       (en[ftfe_pkg::ST_SQRT +: ftfe_pkg::ROOT_W]),
		.rad      (rad_s5),
		.side     (sum_s5),
		.root     (root),
		.side_out (sum_fin)
	);

	always_comb begin
		case (mode_q)
			ftfe_pkg::MODE_SUM: begin
				result = (sum_fin > ftfe_pkg::FORCE_MAX) ? ftfe_pkg::FORCE_MAX : sum_fin;
			end
			ftfe_pkg::MODE_VECTOR: begin
				result = (root > ftfe_pkg::FORCE_MAX) ? ftfe_pkg::FORCE_MAX : root;
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[ftfe_pkg::ST_OUT]) begin
			result_q <= result;
		end
	end

	assign estimate.force_estimate = result_q;

endmodule
`default_nettype wire

[bench/fingertip_taxel_force_estimator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fingertip_taxel_force_estimator_tb
// Self-checking bench for the fingertip force estimator. A queue of planned
// frames and mode writes feeds a clocked driver; a clocked monitor compares
// every estimate with a value computed in the bench from the same frame and
// mode. Both sides idle at random, and the receiver holds off twice for long.
// ----------------------------------------------------------------------------
module fingertip_taxel_force_estimator_tb;

	localparam int LANES_USED   = 12;
	localparam int RESET_CYCLES = 7;
	localparam int PHASES       = 8;
	localparam int PHASE_FRAMES = 230;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 30;
	localparam int QUIET_LIMIT  = 2000;
	localparam int PRINT_LIMIT  = 20;
	localparam logic [ftfe_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef ftfe_pkg::taxel_t [ftfe_pkg::LANE_MAX-1:0] frame_t;

	typedef struct packed {
		logic                         set_mode;
		logic [ftfe_pkg::MODE_W-1:0]  mode;
		frame_t                       tx;
	} plan_item_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                          frame_valid = 1'b0;
	frame_t                        tx_drive    = '0;
	logic                          cfg_valid   = 1'b0;
	logic [ftfe_pkg::MODE_W-1:0]   cfg_mode    = '0;
	logic                          est_ready   = 1'b0;

	plan_item_t                    frame_plan [$];
	logic [ftfe_pkg::FORCE_W-1:0]  force_due [$];
	logic [ftfe_pkg::MODE_W-1:0]   mode_shadow = ftfe_pkg::MODE_SUM;
	int unsigned         frames_sent = 0;
	int unsigned         estimates_taken = 0;
	int unsigned         fails = 0;

	int unsigned tx_gap = 0, tx_stretch = 0;
	bit          tx_calm = 0;
	int unsigned rx_hold = 0, rx_stretch = 0;
	bit          rx_calm = 0;

	ftfe_frame_if    frame_ch ();
	ftfe_estimate_if est_ch ();
	ftfe_cfg_if      cfg_ch ();

	assign frame_ch.valid    = frame_valid;
	assign frame_ch.taxel_0  = tx_drive[0];
	assign frame_ch.taxel_1  = tx_drive[1];
	assign frame_ch.taxel_2  = tx_drive[2];
	assign frame_ch.taxel_3  = tx_drive[3];
	assign frame_ch.taxel_4  = tx_drive[4];
	assign frame_ch.taxel_5  = tx_drive[5];
	assign frame_ch.taxel_6  = tx_drive[6];
	assign frame_ch.taxel_7  = tx_drive[7];
	assign frame_ch.taxel_8  = tx_drive[8];
	assign frame_ch.taxel_9  = tx_drive[9];
	assign frame_ch.taxel_10 = tx_drive[10];
	assign frame_ch.taxel_11 = tx_drive[11];
	assign est_ch.ready      = est_ready;
	assign cfg_ch.valid      = cfg_valid;
	assign cfg_ch.force_mode = cfg_mode;

	fingertip_taxel_force_estimator #(
		.TAXEL_COUNT(LANES_USED)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame_ch),
		.estimate(est_ch),
		.cfg(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// expected estimate for one frame under the given mode
	function automatic logic [ftfe_pkg::FORCE_W-1:0] estimate_force(
			logic [ftfe_pkg::MODE_W-1:0] mode, frame_t tx);
		int nx [ftfe_pkg::LANE_MAX] = '{-32767, -13093, -13093, -32767, -25780, -10128,
			0, 10128, 25780, 32767, 13093, 13093};
		int ny [ftfe_pkg::LANE_MAX] = '{0, 0, 0, 0, 19764, 15652, 32767, 15652, 19764,
			0, 0, 0};
		int nz [ftfe_pkg::LANE_MAX] = '{0, 30039, 30039, 0, 4306, 26948, 0, 26948, 4306,
			0, 30039, 30039};
		longint ax, ay, az;
		logic [63:0] total, sq, root, trial;
		total = 0;
		ax = 0;
		ay = 0;
		az = 0;
		if (mode == ftfe_pkg::MODE_SUM) begin
			for (int i = 0; i < LANES_USED; i++)
				total += 64'(tx[i]);
		end else if (mode == ftfe_pkg::MODE_VECTOR) begin
			for (int i = 0; i < LANES_USED; i++) begin
				ax += longint'(tx[i]) * nx[i];
				ay += longint'(tx[i]) * ny[i];
				az += longint'(tx[i]) * nz[i];
			end
			if (ax < 0) ax = -ax;
			if (ay < 0) ay = -ay;
			if (az < 0) az = -az;
			sq = ax * ax + ay * ay + az * az;
			// floor square root, one bit at a time from the top
			root = 0;
			for (int b = 31; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= sq)
					root = trial;
			end
			total = root >> 15;
		end
		return (total > ftfe_pkg::FORCE_MAX) ? ftfe_pkg::FORCE_MAX
			: total[ftfe_pkg::FORCE_W-1:0];
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic frame_t lone_taxel(int lane, ftfe_pkg::taxel_t v);
		frame_t f;
		f = '0;
		f[lane] = v;
		return f;
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		int unsigned style;
		style = $urandom_range(0, 9);
		for (int i = 0; i < ftfe_pkg::LANE_MAX; i++) begin
			case (style)
				5: f[i] = ftfe_pkg::taxel_t'($urandom_range(0, 15));
				6: f[i] = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
				7: f[i] = ($urandom_range(0, 3) == 0)
					? ftfe_pkg::taxel_t'($urandom_range(0, 4095)) : 12'h000;
				8: f[i] = ftfe_pkg::taxel_t'($urandom_range(4000, 4095));
				default: f[i] = ftfe_pkg::taxel_t'($urandom_range(0, 4095));
			endcase
		end
		if (style == 9)
			f = lone_taxel(int'($urandom_range(0, ftfe_pkg::LANE_MAX - 1)),
				ftfe_pkg::taxel_t'($urandom_range(0, 4095)));
		return f;
	endfunction

	task automatic add_frame(frame_t f);
		frame_plan.push_back('{set_mode: 1'b0, mode: '0, tx: f});
	endtask

	task automatic add_mode(logic [ftfe_pkg::MODE_W-1:0] m);
		frame_plan.push_back('{set_mode: 1'b1, mode: m, tx: '0});
	endtask

	task automatic note_failure(string msg);
		if (fails < PRINT_LIMIT)
			$display("%0t ns: %s", $time, msg);
		fails++;
	endtask

	// driver: frames and mode writes in plan order, mode writes only when drained
	always @(posedge clk) begin : frame_driver
		logic hold_frame, hold_cfg;
		if (arst_n) begin
			hold_frame = frame_valid && !frame_ch.ready;
			hold_cfg   = cfg_valid && !cfg_ch.ready;
			if (frame_valid && frame_ch.ready) begin
				force_due.push_back(estimate_force(mode_shadow, frame_plan[0].tx));
				frame_plan.pop_front();
				frames_sent++;
				tx_gap = tx_calm ? 0 : idle_len();
			end
			if (cfg_valid && cfg_ch.ready) begin
				mode_shadow = frame_plan[0].mode;
				frame_plan.pop_front();
			end
			if (tx_stretch == 0) begin
				tx_stretch = $urandom_range(30, 120);
				tx_calm = ($urandom_range(0, 3) == 0);
			end
			tx_stretch--;
			if (!hold_frame && !hold_cfg) begin
				if (tx_gap > 0 || frame_plan.size() == 0) begin
					if (tx_gap > 0)
						tx_gap--;
					frame_valid <= 1'b0;
					cfg_valid <= 1'b0;
				end else if (frame_plan[0].set_mode) begin
					frame_valid <= 1'b0;
					// wait until every word in flight has come out
					if (frames_sent == estimates_taken) begin
						cfg_valid <= 1'b1;
						cfg_mode <= frame_plan[0].mode;
					end else begin
						cfg_valid <= 1'b0;
					end
				end else begin
					frame_valid <= 1'b1;
					tx_drive <= frame_plan[0].tx;
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : estimate_monitor
		logic [ftfe_pkg::FORCE_W-1:0] want;
		if (arst_n) begin
			if (est_ch.valid && est_ch.ready) begin
				if (force_due.size() == 0) begin
					note_failure($sformatf("estimate %0d with none due",
						est_ch.force_estimate));
				end else begin
					want = force_due.pop_front();
					if (est_ch.force_estimate !== want)
						note_failure($sformatf("force_estimate got %0d want %0d",
							est_ch.force_estimate, want));
				end
				estimates_taken <= estimates_taken + 1;
				// long back-pressure so the pipeline fills and stalls the frame side
				if (estimates_taken + 1 == 575 || estimates_taken + 1 == 1500)
					rx_hold = LONG_HOLD;
			end
			if (rx_stretch == 0) begin
				rx_stretch = $urandom_range(30, 120);
				rx_calm = ($urandom_range(0, 3) == 0);
			end
			rx_stretch--;
			if (rx_hold > 0) begin
				rx_hold--;
				est_ready <= 1'b0;
			end else begin
				est_ready <= 1'b1;
				if (!rx_calm)
					rx_hold = idle_len();
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (frame_valid && frame_ch.ready) || (est_ch.valid && est_ch.ready)
					|| (cfg_valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin : run_control
		logic [ftfe_pkg::MODE_W-1:0] phase_mode [PHASES] = '{ftfe_pkg::MODE_VECTOR,
			ftfe_pkg::MODE_SUM, ftfe_pkg::MODE_ZERO, ftfe_pkg::MODE_VECTOR, MODE_SPARE,
			ftfe_pkg::MODE_SUM, ftfe_pkg::MODE_VECTOR, ftfe_pkg::MODE_VECTOR};
		frame_t f;

		add_mode(ftfe_pkg::MODE_SUM);
		add_frame('0);
		add_frame('1);
		add_frame({ftfe_pkg::LANE_MAX{12'hAAA}});
		add_frame({ftfe_pkg::LANE_MAX{12'h555}});

		add_mode(ftfe_pkg::MODE_VECTOR);
		add_frame('0);
		add_frame('1);
		add_frame(lone_taxel(0, 12'hFFF));
		add_frame(lone_taxel(9, 12'hFFF));
		add_frame(lone_taxel(6, 12'hFFF));
		add_frame(lone_taxel(4, 12'h001));
		// z-heavy taxels: x parts cancel, large z
		f = '0;
		f[1] = '1;
		f[2] = '1;
		f[5] = '1;
		f[7] = '1;
		f[10] = '1;
		f[11] = '1;
		add_frame(f);
		// opposite normals cancel to zero
		f = '0;
		f[0] = '1;
		f[9] = '1;
		add_frame(f);

		add_mode(ftfe_pkg::MODE_ZERO);
		add_frame('1);
		add_frame(random_frame());
		add_mode(MODE_SPARE);
		add_frame('1);
		add_frame(random_frame());

		for (int p = 0; p < PHASES; p++) begin
			add_mode(phase_mode[p]);
			for (int n = 0; n < PHASE_FRAMES; n++)
				add_frame(random_frame());
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (frame_plan.size() != 0 || frames_sent != estimates_taken);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (force_due.size() != 0)
			note_failure($sformatf("%0d estimates never delivered", force_due.size()));

		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[filelist.f]
rtl/ftfe_pkg.sv
rtl/ftfe_frame_if.sv
rtl/ftfe_estimate_if.sv
rtl/ftfe_cfg_if.sv
rtl/ftfe_lane.sv
rtl/ftfe_merge.sv
rtl/ftfe_square.sv
rtl/ftfe_isqrt.sv
rtl/fingertip_taxel_force_estimator.sv
bench/fingertip_taxel_force_estimator_tb.sv
